// File: rtl/core/pva_pkg.sv
package pva_pkg;

	// Default voice count for the top level.
	localparam int NUM_VOICES_DEF = 16;

	// Field widths fixed by the word formats.
	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int VIDX_W = 4;

	// Command codes of the input word.
	localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [1:0] CMD_ALL_OFF  = 2'd2;
	localparam logic [1:0] CMD_ENV_DONE = 2'd3;

	// Action codes of the result word.
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_OFF  = 2'd1;
	localparam logic [1:0] ACT_ON   = 2'd2;

	// Modulation envelope gate codes of the result word.
	localparam logic [1:0] MOD_NONE    = 2'd0;
	localparam logic [1:0] MOD_RETRIG  = 2'd1;
	localparam logic [1:0] MOD_RELEASE = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
		logic [VIDX_W-1:0] voice_sel;
	} in_word_t;

	typedef struct packed {
		logic [VIDX_W-1:0] voice_index;
		logic [1:0]        action;
		logic [NOTE_W-1:0] out_note;
		logic [VEL_W-1:0]  out_velocity;
		logic [NOTE_W-1:0] highest_note;
		logic [1:0]        mod_gate;
		logic              last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_ON_REL,
		ST_ON_GATE,
		ST_OFF_RES,
		ST_ALL_SCAN,
		ST_ALL_NONE,
		ST_ENV_RES
	} state_t;

	// Which result word the datapath builds and commits this cycle.
	typedef enum logic [2:0] {
		EM_NONE,
		EM_ON_REL,
		EM_ON_GATE,
		EM_OFF_RES,
		EM_ALL_OFF,
		EM_ALL_NONE,
		EM_ENV_RES
	} emit_t;

	typedef struct packed {
		logic  accept;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  rd_issue;
		emit_t emit;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] new_cmd;
		logic [1:0] cmd;
		logic       cnt_last;
		logic       cnt_end;
		logic       cur_playing;
		logic       rest_none;
		logic       hit;
		logic       out_free;
	} stat_t;

endpackage

// File: rtl/core/pva_ram.sv
module pva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/pva_ctrl.sv
module pva_ctrl
	import pva_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	input  stat_t  stat,
	output ctrl_t  ctl,
	output logic   cmd_stall
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (stat.new_cmd)
						CMD_ALL_OFF:  state_d = ST_ALL_SCAN;
						CMD_ENV_DONE: state_d = ST_ENV_RES;
						default:      state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.cnt_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				if (stat.cmd == CMD_NOTE_ON) begin
					state_d = ST_ON_REL;
				end else begin
					state_d = ST_OFF_RES;
				end
			end
			ST_ON_REL: begin
				if (!stat.hit || stat.out_free) begin
					state_d = ST_ON_GATE;
				end
			end
			ST_ALL_SCAN: begin
				if (stat.cnt_end) begin
					state_d = ST_ALL_NONE;
				end else if (stat.cur_playing && stat.out_free && stat.rest_none) begin
					state_d = ST_IDLE;
				end
			end
			ST_ON_GATE, ST_OFF_RES, ST_ALL_NONE, ST_ENV_RES: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		ctl      = '0;
		ctl.emit = EM_NONE;
		case (state_q)
			ST_IDLE: begin
				ctl.accept  = cmd_valid;
				ctl.cnt_clr = 1'b1;
			end
			ST_SCAN: begin
				ctl.rd_issue = 1'b1;
				ctl.cnt_inc  = 1'b1;
			end
			ST_ON_REL: begin
				if (stat.hit && stat.out_free) begin
					ctl.emit = EM_ON_REL;
				end
			end
			ST_ON_GATE: begin
				if (stat.out_free) begin
					ctl.emit = EM_ON_GATE;
				end
			end
			ST_OFF_RES: begin
				if (stat.out_free) begin
					ctl.emit = EM_OFF_RES;
				end
			end
			ST_ALL_SCAN: begin
				if (!stat.cnt_end) begin
					if (!stat.cur_playing) begin
						ctl.cnt_inc = 1'b1;
					end else if (stat.out_free) begin
						ctl.cnt_inc = 1'b1;
						ctl.emit    = EM_ALL_OFF;
					end
				end
			end
			ST_ALL_NONE: begin
				if (stat.out_free) begin
					ctl.emit = EM_ALL_NONE;
				end
			end
			ST_ENV_RES: begin
				if (stat.out_free) begin
					ctl.emit = EM_ENV_RES;
				end
			end
			default: ;
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);

endmodule

// File: rtl/core/pva_datapath.sv
module pva_datapath
	import pva_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  cmd_word,
	input  ctrl_t     ctl,
	output stat_t     stat,
	input  logic      res_stall,
	output logic      res_valid,
	output out_word_t res_word
);

	localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CW = $clog2(NUM_VOICES + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(NUM_VOICES - 1);
	localparam logic [CW-1:0] CNT_END  = CW'(NUM_VOICES);

	// Widen or narrow a voice number to the result field.
	function automatic logic [VIDX_W-1:0] to_vidx(input logic [IW-1:0] idx);
		logic [IW+VIDX_W-1:0] wide;
		wide = {{VIDX_W{1'b0}}, idx};
		return wide[VIDX_W-1:0];
	endfunction

	logic [1:0]            new_cmd;
	logic [1:0]            cmd_q;
	logic [NOTE_W-1:0]     note_q;
	logic [VEL_W-1:0]      vel_q;
	logic [VIDX_W-1:0]     sel_q;
	logic [NUM_VOICES-1:0] playing_q;
	logic [NUM_VOICES-1:0] playing_d;
	logic [NUM_VOICES-1:0] env_q;
	logic [NUM_VOICES-1:0] env_d;
	logic [NUM_VOICES-1:0] cur_mask;
	logic [NOTE_W-1:0]     top_note_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         cnt_idx;
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic [NOTE_W-1:0]     ram_rdata;
	logic                  pl_s1;
	logic                  en_s1;
	logic                  match_s1;
	logic                  live_s1;
	logic                  hit_q;
	logic [IW-1:0]         hit_idx_q;
	logic                  free_q;
	logic [IW-1:0]         free_idx_q;
	logic                  rls_q;
	logic [IW-1:0]         rls_idx_q;
	logic                  any_q;
	logic [NOTE_W-1:0]     top_q;
	logic [IW-1:0]         pick_idx;
	logic [NOTE_W-1:0]     new_top_on;
	logic                  rest_none;
	logic                  out_free;
	logic                  emit_any;
	out_word_t             out_d;

	// A note on with zero velocity is handled as a note off.
	assign new_cmd = (cmd_word.command == CMD_NOTE_ON && cmd_word.velocity == '0) ?
		CMD_NOTE_OFF : cmd_word.command;

	// Input word capture.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= new_cmd;
			note_q <= cmd_word.note;
			vel_q  <= cmd_word.velocity;
			sel_q  <= cmd_word.voice_sel;
		end
	end

	// Voice counter for the note scan and the all-notes-off sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign cnt_idx = cnt_q[IW-1:0];

	// Read stage: the note of the voice addressed last cycle arrives now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_idx;
	end

	pva_ram #(
		.WIDTH(NOTE_W),
		.DEPTH(NUM_VOICES)
	) u_note_ram (
		.clk  (clk),
		.we   (ctl.emit == EM_ON_GATE),
		.waddr(pick_idx),
		.wdata(note_q),
		.re   (ctl.rd_issue),
		.raddr(cnt_idx),
		.rdata(ram_rdata)
	);

	// The first playing voice with the note is the one released; it counts as
	// not playing for every later decision of the same word.
	assign pl_s1    = playing_q[idx_s1];
	assign en_s1    = env_q[idx_s1];
	assign match_s1 = pl_s1 && (ram_rdata == note_q) && !hit_q;
	assign live_s1  = pl_s1 && !match_s1;

	// Scan results: matching voice, first free voice, first voice in release,
	// and the highest note still held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			rls_q      <= 1'b0;
			rls_idx_q  <= '0;
			any_q      <= 1'b0;
			top_q      <= '0;
		end else if (ctl.accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			rls_q  <= 1'b0;
			any_q  <= 1'b0;
			top_q  <= '0;
		end else if (vld_s1) begin
			if (match_s1) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!live_s1 && !en_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (!live_s1 && en_s1 && !rls_q) begin
				rls_q     <= 1'b1;
				rls_idx_q <= idx_s1;
			end
			if (live_s1) begin
				any_q <= 1'b1;
				if (ram_rdata > top_q) begin
					top_q <= ram_rdata;
				end
			end
		end
	end

	assign pick_idx   = free_q ? free_idx_q : (rls_q ? rls_idx_q : '0);
	assign new_top_on = (note_q > top_note_q) ? note_q : top_note_q;

	// Whether any voice other than the one at the current sweep position still plays.
	always_comb begin
		for (int v = 0; v < NUM_VOICES; v++) begin
			cur_mask[v] = (cnt_idx == IW'(v));
		end
	end

	assign rest_none = ~|(playing_q & ~cur_mask);

	// Voice flag updates, committed with the result that reports them.
	always_comb begin
		playing_d = playing_q;
		env_d     = env_q;
		case (ctl.emit)
			EM_ON_REL: playing_d[hit_idx_q] = 1'b0;
			EM_ON_GATE: begin
				playing_d[pick_idx] = 1'b1;
				env_d[pick_idx]     = 1'b1;
			end
			EM_OFF_RES: begin
				if (hit_q) begin
					playing_d[hit_idx_q] = 1'b0;
				end
			end
			EM_ALL_OFF: playing_d[cnt_idx] = 1'b0;
			EM_ENV_RES: begin
				for (int v = 0; v < NUM_VOICES; v++) begin
					if (int'(sel_q) == v) begin
						env_d[v] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= '0;
			env_q      <= '0;
			top_note_q <= '0;
		end else begin
			playing_q <= playing_d;
			env_q     <= env_d;
			if (ctl.accept && new_cmd == CMD_ALL_OFF) begin
				top_note_q <= '0;
			end else if (ctl.emit == EM_ON_GATE) begin
				top_note_q <= new_top_on;
			end else if (ctl.emit == EM_OFF_RES) begin
				top_note_q <= top_q;
			end
		end
	end

	// Result word assembly.
	always_comb begin
		out_d = '0;
		case (ctl.emit)
			EM_ON_REL: begin
				out_d.voice_index  = to_vidx(hit_idx_q);
				out_d.action       = ACT_OFF;
				out_d.highest_note = top_note_q;
				out_d.mod_gate     = MOD_NONE;
			end
			EM_ON_GATE: begin
				out_d.voice_index  = to_vidx(pick_idx);
				out_d.action       = ACT_ON;
				out_d.out_note     = note_q;
				out_d.out_velocity = vel_q;
				out_d.highest_note = new_top_on;
				out_d.mod_gate     = MOD_RETRIG;
				out_d.last         = 1'b1;
			end
			EM_OFF_RES: begin
				out_d.voice_index  = hit_q ? to_vidx(hit_idx_q) : '0;
				out_d.action       = hit_q ? ACT_OFF : ACT_NONE;
				out_d.highest_note = top_q;
				out_d.mod_gate     = any_q ? MOD_NONE : MOD_RELEASE;
				out_d.last         = 1'b1;
			end
			EM_ALL_OFF: begin
				out_d.voice_index = to_vidx(cnt_idx);
				out_d.action      = ACT_OFF;
				out_d.mod_gate    = rest_none ? MOD_RELEASE : MOD_NONE;
				out_d.last        = rest_none;
			end
			EM_ALL_NONE: begin
				out_d.action   = ACT_NONE;
				out_d.mod_gate = MOD_RELEASE;
				out_d.last     = 1'b1;
			end
			EM_ENV_RES: begin
				out_d.voice_index  = sel_q;
				out_d.action       = ACT_NONE;
				out_d.highest_note = top_note_q;
				out_d.mod_gate     = MOD_NONE;
				out_d.last         = 1'b1;
			end
			default: ;
		endcase
	end

	// Output register.
	assign out_free = !res_valid || !res_stall;
	assign emit_any = (ctl.emit != EM_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit_any) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			res_word <= out_d;
		end
	end

	// Status to the controller.
	assign stat.new_cmd     = new_cmd;
	assign stat.cmd         = cmd_q;
	assign stat.cnt_last    = (cnt_q == CNT_LAST);
	assign stat.cnt_end     = (cnt_q == CNT_END);
	assign stat.cur_playing = (cnt_q != CNT_END) && playing_q[cnt_idx];
	assign stat.rest_none   = rest_none;
	assign stat.hit         = hit_q;
	assign stat.out_free    = out_free;

endmodule

// File: rtl/core/poly_voice_allocator_core.sv
// Channel  Direction  Handshake                  Word
// cmd      in         cmd_valid / cmd_stall      in_word_t  (command, note, velocity, voice_sel)
// res      out        res_valid / res_stall      out_word_t (per voice released/started, or one)
//
// Note on and note off scan the voice note memory one voice a cycle; all notes off
// sweeps the voices in turn, and an envelope-finished word needs no scan. One word
// is handled at a time. Reset clears every voice flag and the highest note at once,
// so no word waits after reset. A stalled result holds the sequencer in place.
module poly_voice_allocator_core
	import pva_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_word_t  cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	ctrl_t ctl;
	stat_t stat;

	// Sequencer.
	pva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.stat     (stat),
		.ctl      (ctl),
		.cmd_stall(cmd_stall)
	);

	// Voice state, scan logic and result register.
	pva_datapath #(
		.NUM_VOICES(NUM_VOICES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_word (cmd_word),
		.ctl      (ctl),
		.stat     (stat),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_word (res_word)
	);

endmodule

// File: tb/tb_poly_voice_allocator_core.sv
module tb_poly_voice_allocator_core
	import pva_pkg::*;
();

	localparam int VOICES        = NUM_VOICES_DEF;
	localparam int IN_W          = $bits(in_word_t);
	localparam int RANDOM_WORDS  = 360;
	localparam int HOLD_AT       = 280;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	in_word_t  cmd_word;
	logic      res_valid;
	logic      res_stall;
	out_word_t res_word;

	poly_voice_allocator_core #(
		.NUM_VOICES(VOICES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	// Shadow copy of the voice table, updated as each command word is taken.
	logic              playing    [VOICES];
	logic [NOTE_W-1:0] voice_note [VOICES];
	logic              env_busy   [VOICES];
	logic [NOTE_W-1:0] top_note;

	// Result words still owed by the block, oldest first.
	out_word_t voice_events [$];

	typedef struct {
		in_word_t  w;
		logic      fixed;
		out_word_t want;
	} drill_row_t;

	drill_row_t drill [$];

	int   gate_ons;
	int   gate_offs;
	int   steals;
	int   results_seen;
	int   mismatch_count;
	int   words_sent;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_rx;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append one word to the results still owed.
	function automatic void owe(out_word_t r);
		voice_events = {voice_events, r};
	endfunction

	// Queue one result word; the highest note is taken as it stands now.
	function automatic void emit(int v, logic [1:0] act, logic [NOTE_W-1:0] nt,
			logic [VEL_W-1:0] vel, logic [1:0] mod);
		out_word_t r;
		r.voice_index  = v[VIDX_W-1:0];
		r.action       = act;
		r.out_note     = nt;
		r.out_velocity = vel;
		r.highest_note = top_note;
		r.mod_gate     = mod;
		r.last         = 1'b0;
		owe(r);
	endfunction

	// Release the first playing voice that holds this note, if there is one.
	function automatic logic release_one(logic [NOTE_W-1:0] nt);
		for (int i = 0; i < VOICES; i++) begin
			if (playing[i] && voice_note[i] == nt) begin
				playing[i] = 1'b0;
				gate_offs++;
				emit(i, ACT_OFF, '0, '0, MOD_NONE);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Work out every result word that one command word causes.
	function automatic void allocate(in_word_t w);
		logic [1:0]        cmd;
		logic              hit;
		logic              any;
		logic [NOTE_W-1:0] top;
		int                pick;
		int                first;
		out_word_t         tail;
		cmd   = w.command;
		first = voice_events.size();
		// A note on at zero velocity is a note off.
		if (cmd == CMD_NOTE_ON && w.velocity == '0)
			cmd = CMD_NOTE_OFF;
		case (cmd)
			CMD_NOTE_ON: begin
				void'(release_one(w.note));
				pick = -1;
				for (int i = 0; i < VOICES; i++)
					if (pick < 0 && !playing[i] && !env_busy[i])
						pick = i;
				for (int i = 0; i < VOICES; i++)
					if (pick < 0 && !playing[i] && env_busy[i])
						pick = i;
				// Every voice busy: voice 0 is stolen without a gate off.
				if (pick < 0) begin
					pick = 0;
					steals++;
				end
				if (w.note > top_note)
					top_note = w.note;
				playing[pick]    = 1'b1;
				env_busy[pick]   = 1'b1;
				voice_note[pick] = w.note;
				gate_ons++;
				emit(pick, ACT_ON, w.note, w.velocity, MOD_RETRIG);
			end
			CMD_NOTE_OFF: begin
				hit = release_one(w.note);
				any = 1'b0;
				top = '0;
				for (int i = 0; i < VOICES; i++) begin
					if (playing[i]) begin
						any = 1'b1;
						if (voice_note[i] > top)
							top = voice_note[i];
					end
				end
				top_note = top;
				if (hit) begin
					tail = voice_events.pop_back();
					tail.highest_note = top_note;
					tail.mod_gate     = any ? MOD_NONE : MOD_RELEASE;
					owe(tail);
				end else begin
					emit(0, ACT_NONE, '0, '0, any ? MOD_NONE : MOD_RELEASE);
				end
			end
			CMD_ALL_OFF: begin
				top_note = '0;
				for (int i = 0; i < VOICES; i++) begin
					if (playing[i]) begin
						playing[i] = 1'b0;
						gate_offs++;
						emit(i, ACT_OFF, '0, '0, MOD_NONE);
					end
				end
				if (voice_events.size() == first) begin
					emit(0, ACT_NONE, '0, '0, MOD_RELEASE);
				end else begin
					tail = voice_events.pop_back();
					tail.mod_gate = MOD_RELEASE;
					owe(tail);
				end
			end
			default: begin
				if (int'(w.voice_sel) < VOICES)
					env_busy[w.voice_sel] = 1'b0;
				emit(int'(w.voice_sel), ACT_NONE, '0, '0, MOD_NONE);
			end
		endcase
		tail = voice_events.pop_back();
		tail.last = 1'b1;
		owe(tail);
	endfunction

	// Mostly well-formed traffic: notes off for held notes, envelope ends for
	// voices in release, and a narrow band of notes so that repeats occur.
	function automatic in_word_t compose();
		in_word_t w;
		int       pool [$];
		int       r;
		w = in_word_t'(IN_W'($urandom));
		r = $urandom_range(99);
		if (r < 45) begin
			w.command = CMD_NOTE_ON;
			if ($urandom_range(1) == 1)
				w.note = 7'(48 + $urandom_range(11));
			if ($urandom_range(15) == 0)
				w.velocity = '0;
		end else if (r < 75) begin
			w.command = CMD_NOTE_OFF;
			for (int i = 0; i < VOICES; i++)
				if (playing[i])
					pool = {pool, i};
			if (pool.size() != 0 && $urandom_range(4) != 0)
				w.note = voice_note[pool[$urandom_range(pool.size() - 1)]];
		end else if (r < 93) begin
			w.command = CMD_ENV_DONE;
			for (int i = 0; i < VOICES; i++)
				if (!playing[i] && env_busy[i])
					pool = {pool, i};
			if (pool.size() != 0 && $urandom_range(3) != 0)
				w.voice_sel = 4'(pool[$urandom_range(pool.size() - 1)]);
		end else begin
			w.command = CMD_ALL_OFF;
		end
		return w;
	endfunction

	function automatic void add_row(logic [1:0] cmd, int nt, int vel, int sel,
			logic fixed = 1'b0, out_word_t want = '0);
		drill_row_t r;
		r.w.command   = cmd;
		r.w.note      = 7'(nt);
		r.w.velocity  = 7'(vel);
		r.w.voice_sel = 4'(sel);
		r.fixed       = fixed;
		r.want        = want;
		drill = {drill, r};
	endfunction

	// Directed words. Rows with a written-out result are simple enough to read
	// straight off; the rest are left to the shadow model.
	function automatic void load_drill();
		// Quiet block: envelope end on the top voice, a stray note off, all off.
		add_row(CMD_ENV_DONE, 0, 0, 15, 1'b1,
			out_word_t'{4'd15, ACT_NONE, 7'd0, 7'd0, 7'd0, MOD_NONE, 1'b1});
		add_row(CMD_NOTE_OFF, 127, 127, 0, 1'b1,
			out_word_t'{4'd0, ACT_NONE, 7'd0, 7'd0, 7'd0, MOD_RELEASE, 1'b1});
		add_row(CMD_ALL_OFF, 0, 0, 0, 1'b1,
			out_word_t'{4'd0, ACT_NONE, 7'd0, 7'd0, 7'd0, MOD_RELEASE, 1'b1});
		// Extreme notes and velocities on the first two free voices.
		add_row(CMD_NOTE_ON, 0, 127, 0, 1'b1,
			out_word_t'{4'd0, ACT_ON, 7'd0, 7'd127, 7'd0, MOD_RETRIG, 1'b1});
		add_row(CMD_NOTE_ON, 127, 1, 0, 1'b1,
			out_word_t'{4'd1, ACT_ON, 7'd127, 7'd1, 7'd127, MOD_RETRIG, 1'b1});
		// Repeated note, then a note on at zero velocity for a note not held.
		add_row(CMD_NOTE_ON, 127, 64, 0);
		add_row(CMD_NOTE_ON, 60, 0, 0);
		add_row(CMD_NOTE_OFF, 0, 0, 0);
		add_row(CMD_ENV_DONE, 0, 0, 0, 1'b1,
			out_word_t'{4'd0, ACT_NONE, 7'd0, 7'd0, 7'd127, MOD_NONE, 1'b1});
		// Fill every free voice, then take the one in release, then steal.
		for (int i = 0; i < 14; i++)
			add_row(CMD_NOTE_ON, 30 + 3 * i, 9 * i + 5, i);
		add_row(CMD_NOTE_ON, 100, 90, 0);
		add_row(CMD_NOTE_ON, 101, 91, 0);
		// Envelope end on a voice that still plays, then all off with all held.
		add_row(CMD_ENV_DONE, 0, 0, 5);
		add_row(CMD_ALL_OFF, 0, 0, 0);
	endfunction

	task automatic flag(string msg);
		mismatch_count++;
		$display("MISMATCH %s", msg);
	endtask

	task automatic same(string field, logic [6:0] got, logic [6:0] want);
		if (got !== want)
			flag($sformatf("result %0d %s: got %0d, want %0d", results_seen, field, got, want));
	endtask

	task automatic check_result(out_word_t got);
		out_word_t want;
		if (voice_events.size() == 0) begin
			flag($sformatf("result %0d arrived with none owed: %h", results_seen, got));
		end else begin
			want = voice_events.pop_front();
			same("voice_index", 7'(got.voice_index), 7'(want.voice_index));
			same("action", 7'(got.action), 7'(want.action));
			same("out_note", got.out_note, want.out_note);
			same("out_velocity", got.out_velocity, want.out_velocity);
			same("highest_note", got.highest_note, want.highest_note);
			same("mod_gate", 7'(got.mod_gate), 7'(want.mod_gate));
			same("last", 7'(got.last), 7'(want.last));
		end
		results_seen++;
	endtask

	// Offer one command word, with random idle cycles first, and update the
	// shadow model once the block has taken it.
	task automatic offer(in_word_t w, logic fixed, out_word_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_sent <= words_sent + 1;
		allocate(w);
		if (fixed) begin
			void'(voice_events.pop_back());
			owe(want);
		end
	endtask

	// Result side: check each word taken, then decide the next stall.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				check_result(res_word);
			res_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// One long hold-off on the result side while commands keep coming, so that
	// the block backs up and stalls its input.
	initial begin
		hold_rx = 1'b0;
		@(posedge clk);
		while (words_sent < HOLD_AT)
			@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int waited;
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd_word       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		gate_ons       = 0;
		gate_offs      = 0;
		steals         = 0;
		results_seen   = 0;
		mismatch_count = 0;
		words_sent     = 0;
		for (int i = 0; i < VOICES; i++) begin
			playing[i]    = 1'b0;
			voice_note[i] = '0;
			env_busy[i]   = 1'b0;
		end
		top_note = '0;
		load_drill();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words with light idling on both sides.
		send_idle_pct = 20;
		recv_stall_pct <= 20;
		foreach (drill[i])
			offer(drill[i].w, drill[i].fixed, drill[i].want);

		// Random words in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 10;
					recv_stall_pct <= 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct <= 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / 3; n++)
				offer(compose(), 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		// Drain whatever is still owed, then let the block settle.
		waited = 0;
		while (voice_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (voice_events.size() != 0)
			flag($sformatf("%0d result words never arrived", voice_events.size()));

		$display("Covered %0d command words and %0d result words: %0d voices started,",
			words_sent, results_seen, gate_ons);
		$display("%0d released and %0d stolen, with one hold-off of %0d cycles; %0d mismatches.",
			gate_offs, steals, HOLD_CYCLES, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
